>>> design/b2da_pkg.sv
// Package for the binary to decimal ASCII converter.
// Shared widths, the ASCII offset and the control struct between top level and core.
// No dependencies.
package b2da_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 6;
    localparam int DIGIT_W   = 4;
    localparam int WIDEST    = 10;
    localparam int BIT_CNT_W = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic digit_shift;
    } b2da_ctl_t;

endpackage

>>> design/b2da_core.sv
// Shift-and-add-3 core: binary shift register plus BCD digit register.
// Depends on b2da_pkg; driven at most one command per cycle by binary_to_decimal_ascii.
module b2da_core #(
    parameter int KEEP = 10
) (
    input  logic                           clk,
    input  b2da_pkg::b2da_ctl_t            ctl,
    input  logic [b2da_pkg::VALUE_W-1:0]   value,
    output b2da_pkg::digit_t               top_digit
);

    localparam int BCD_W = KEEP * b2da_pkg::DIGIT_W;

    logic [b2da_pkg::VALUE_W-1:0] bin_reg;
    logic [b2da_pkg::VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]             bcd_reg;
    logic [BCD_W-1:0]             bcd_next;
    logic [BCD_W-1:0]             bcd_adj;

    always_comb
    begin
        for (int i = 0; i < KEEP; i++)
        begin
            if (bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                    bcd_reg[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
            end
        end
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        priority if (ctl.load)
        begin
            bin_next = value;
            bcd_next = '0;
        end
        else if (ctl.dabble)
        begin
            bin_next = bin_reg << 1;
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
        end
        else if (ctl.digit_shift)
        begin
            bcd_next = bcd_reg << b2da_pkg::DIGIT_W;
        end
        else
        begin
            bin_next = bin_reg;
            bcd_next = bcd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: b2da_pkg::DIGIT_W];

endmodule

>>> design/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level.
// Depends on b2da_pkg and b2da_core.
//
// Takes one unsigned 32-bit value per transaction and returns its decimal digits as ASCII,
// most significant first, leading zeros dropped (zero gives a single '0'), last_digit set on
// the final one. Only the MAX_DIGITS least significant digits are kept. One value is worked
// on at a time: after acceptance the shift-and-add-3 loop runs its 32 steps, the leading-zero
// scan drops the leading zero digits, then one digit leaves per cycle while the output is
// not stalled.
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]    value,
    output logic                            char_valid,
    input  logic                            char_stall,
    output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
    output logic                            last_digit
);

    localparam int KEEP   = (MAX_DIGITS < b2da_pkg::WIDEST) ? MAX_DIGITS : b2da_pkg::WIDEST;
    localparam int DCNT_W = $clog2(KEEP + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [b2da_pkg::BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [b2da_pkg::BIT_CNT_W-1:0]   bit_cnt_next;
    logic [DCNT_W-1:0]                dig_cnt_reg;
    logic [DCNT_W-1:0]                dig_cnt_next;
    logic                             valid_reg;
    logic                             valid_next;
    logic [b2da_pkg::CHAR_W-1:0]      char_reg;
    logic [b2da_pkg::CHAR_W-1:0]      char_next;
    logic                             last_reg;
    logic                             last_next;

    b2da_pkg::b2da_ctl_t              ctl;
    b2da_pkg::digit_t                 top_digit;
    logic                             out_free;

    b2da_core #(
        .KEEP (KEEP)
    ) u_core (
        .clk       (clk),
        .ctl       (ctl),
        .value     (value),
        .top_digit (top_digit)
    );

    assign out_free   = !valid_reg || !char_stall;
    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        valid_next   = valid_reg && char_stall;
        char_next    = char_reg;
        last_next    = last_reg;
        ctl          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    ctl.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctl.dabble   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W - 1))
                begin
                    dig_cnt_next = DCNT_W'(KEEP);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == '0 && dig_cnt_reg != DCNT_W'(1))
                begin
                    ctl.digit_shift = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    valid_next      = 1'b1;
                    char_next       = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(top_digit);
                    last_next       = (dig_cnt_reg == DCNT_W'(1));
                    ctl.digit_shift = 1'b1;
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DCNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_valid = valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    // digit count never runs out while digits remain to scan or send
    a_dig_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> dig_cnt_reg != '0)
        else $error("digit count empty during scan or emit");

    // scan stops on a nonzero digit unless only the last digit is left
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && $past(state_reg) == ST_SKIP)
            |-> (top_digit != '0 || dig_cnt_reg == DCNT_W'(1)))
        else $error("leading zero reached the output");

    // converted digits are valid BCD
    a_bcd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> top_digit <= 4'd9)
        else $error("digit out of decimal range");

endmodule

>>> bench/binary_to_decimal_ascii_tb.sv
// Testbench for binary_to_decimal_ascii: directed, random, backpressure and streaming
// tests on the decimal ASCII digit stream, with a self-checking digit scoreboard.
// Depends on b2da_pkg and the binary_to_decimal_ascii RTL.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb;

    localparam int DIGITS = 10;

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_exp_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic [b2da_pkg::VALUE_W-1:0]  value = '0;
    logic                          char_valid;
    logic                          char_stall = 1'b0;
    logic [b2da_pkg::CHAR_W-1:0]   digit_char;
    logic                          last_digit;

    digit_exp_t digit_q[$];
    int         error_cnt = 0;
    int         value_cnt = 0;
    int         char_cnt = 0;

    int rx_hold_req = 0;
    int rx_left = 0;
    bit rx_quiet = 1'b0;
    bit rx_stalling = 1'b0;

    binary_to_decimal_ascii #(.MAX_DIGITS(DIGITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .value      (value),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void predict_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
        logic [b2da_pkg::DIGIT_W-1:0] digs[b2da_pkg::WIDEST];
        logic [b2da_pkg::VALUE_W-1:0] rem;
        int                           n;
        int                           kept;
        digit_exp_t                   e;
        rem = v;
        n = 0;
        if (rem == 0)
        begin
            e.ch = b2da_pkg::ASCII_ZERO;
            e.last = 1'b1;
            digit_q.push_back(e);
            return;
        end
        while (rem != 0 && n < b2da_pkg::WIDEST)
        begin
            digs[n] = b2da_pkg::DIGIT_W'(rem % 10);
            rem = rem / 10;
            n++;
        end
        kept = (n > DIGITS) ? DIGITS : n;
        for (int k = kept - 1; k >= 0; k--)
        begin
            e.ch = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digs[k]);
            e.last = (k == 0);
            digit_q.push_back(e);
        end
    endfunction

    // caller is at a rising edge; valid stays high if gap is zero
    task automatic send_value(input logic [b2da_pkg::VALUE_W-1:0] v, input int gap);
        item_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (item_stall);
        predict_digits(v);
        value_cnt++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (digit_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [b2da_pkg::VALUE_W-1:0] random_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned p;
        int              d;
        unique case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:
            begin
                d = $urandom_range(1, 10);
                lo = 1;
                for (int i = 1; i < d; i++)
                    lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                return b2da_pkg::VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
            7: return $urandom_range(0, 20);
            8:
            begin
                d = $urandom_range(0, 9);
                p = 1;
                for (int i = 0; i < d; i++)
                    p = p * 10;
                return b2da_pkg::VALUE_W'(p + $urandom_range(0, 2) - 1);
            end
            default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rx_hold_req != 0)
        begin
            rx_left = rx_hold_req;
            rx_hold_req = 0;
            rx_stalling = 1'b1;
        end
        else if (rx_left > 0)
            rx_left = rx_left - 1;
        else if (rx_quiet)
            rx_stalling = 1'b0;
        else if (rx_stalling || $urandom_range(0, 3) != 0)
        begin
            rx_stalling = 1'b0;
            rx_left = $urandom_range(0, 6);
        end
        else
        begin
            rx_stalling = 1'b1;
            rx_left = pick_gap();
        end
        char_stall <= rx_stalling;
    end

    always @(posedge clk)
    begin
        digit_exp_t e;
        if (rst_n && char_valid && !char_stall)
        begin
            char_cnt++;
            if (digit_q.size() == 0)
            begin
                $error("unexpected transaction: digit_char=%0d last_digit=%0b",
                       digit_char, last_digit);
                error_cnt++;
            end
            else
            begin
                e = digit_q.pop_front();
                if (digit_char !== e.ch)
                begin
                    $error("digit_char: expected %0d, actual %0d", e.ch, digit_char);
                    error_cnt++;
                end
                if (last_digit !== e.last)
                begin
                    $error("last_digit: expected %0b, actual %0b", e.last, last_digit);
                    error_cnt++;
                end
            end
        end
    end

    task automatic test_directed();
        logic [b2da_pkg::VALUE_W-1:0] vals[$];
        vals = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd18,
                32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1000000000, 32'd999999999,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                32'd123456789, 32'd1000000001, 32'h8000_0001, 32'd4000000000,
                32'd0};
        foreach (vals[i])
            send_value(vals[i], pick_gap());
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_value(random_value(), pick_gap());
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_hold_req = 400;
        for (int i = 0; i < 6; i++)
            send_value(random_value(), 0);
        wait_drained();
    endtask

    task automatic test_streaming();
        rx_quiet = 1'b1;
        for (int i = 0; i < 15; i++)
            send_value(random_value(), 0);
        wait_drained();
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(65);
        test_backpressure();
        test_streaming();
        test_random(65);
        wait_drained();
        repeat (60) @(posedge clk);
        $display("Converted %0d values into %0d digit transactions, incl. zero, max, long",
                 value_cnt, char_cnt);
        $display("output holds, back-to-back streaming and random idling on both sides.");
        if (error_cnt == 0 && digit_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
